// ===== hdl/mm64a_pkg.sv =====
// shared constants, types and sequencer states of the murmur64a hash engine
`default_nettype none

package mm64a_pkg;

  // hash constants
  localparam logic [63:0] MurM    = 64'hc6a4a7935bd1e995;
  localparam int unsigned MurR    = 47;
  localparam logic [63:0] MurSeed = 64'h00000000000ce110;

  // low bits of the message length used for seeding (8 to 64)
  localparam int unsigned LengthBits = 32;
  localparam logic [63:0] LenMask =
      (LengthBits >= 64) ? {64{1'b1}} : ((64'd1 << LengthBits) - 64'd1);

  // full word byte count
  localparam logic [3:0] FullBytes = 4'd8;

  typedef enum logic [3:0] {
    StIdle,
    StSeed,
    StDispatch,
    StKMul1,
    StKMul2,
    StHMul,
    StPost,
    StFinal,
    StEmit
  } state_e;

  // request to the shared multiplier: product = operand * MurM mod 2^64
  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/mm64a_if.sv =====
// valid/ready channel interfaces for message words and hash results
`default_nettype none

interface mm64a_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  word_bytes;
  logic [31:0] message_length;
  logic        is_first;
  logic        is_last;

  modport source (
    output valid, message_word, word_bytes, message_length, is_first, is_last,
    input  ready
  );
  modport sink (
    input  valid, message_word, word_bytes, message_length, is_first, is_last,
    output ready
  );
endinterface

interface mm64a_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (
    output valid, hash_value,
    input  ready
  );
  modport sink (
    input  valid, hash_value,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/murmur64a_hash_engine.sv =====
// murmurhash64a engine: one shared multiplier under a word sequencer
// every 64-bit multiply is split into partial products on the shared 32x32 multiplier
// one word at a time: a full word needs the key and hash multiplies,
// a 1-7 byte tail only the hash multiply, an empty word none
// a first word adds a seeding multiply, a last word a finalization multiply
// reset: sequencer idle, running hash zero, no result pending
`default_nettype none

module murmur64a_hash_engine (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mm64a_in_if.sink   in_i,
  mm64a_out_if.source out_o
);

  mm64a_pkg::state_e   state_q, state_d;
  mm64a_pkg::mul_req_t mul_req;
  mm64a_pkg::mul_rsp_t mul_rsp;

  // running (unfinalized) hash, the only state visible across messages
  logic [63:0] h_q, h_d;
  // scratch: mixed key, later the finalized hash
  logic [63:0] k_q, k_d;
  // captured word, already masked to its valid bytes
  logic [63:0] w_q, w_d;
  logic [3:0]  nb_q, nb_d;
  logic        last_q, last_d;

  logic        out_valid_q;
  logic [63:0] out_hash_q;
  logic        out_load;

  logic [3:0]  nb_sat;
  logic [63:0] byte_mask;
  logic [63:0] len_ext;
  logic [63:0] prod_mix;

  mm64a_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // byte count above eight counts as a full word; also the byte mask, seed length and product mix
  always_comb begin
    nb_sat = (in_i.word_bytes > mm64a_pkg::FullBytes) ? mm64a_pkg::FullBytes
                                                      : in_i.word_bytes;
    if (nb_sat == mm64a_pkg::FullBytes) begin
      byte_mask = {64{1'b1}};
    end else begin
      byte_mask = (64'd1 << {nb_sat[2:0], 3'b000}) - 64'd1;
    end
    len_ext  = {32'd0, in_i.message_length} & mm64a_pkg::LenMask;
    prod_mix = mul_rsp.product ^ (mul_rsp.product >> mm64a_pkg::MurR);
  end

  // word sequencer
  always_comb begin
    state_d         = state_q;
    h_d             = h_q;
    k_d             = k_q;
    w_d             = w_q;
    nb_d            = nb_q;
    last_d          = last_q;
    mul_req.start   = 1'b0;
    mul_req.operand = '0;
    out_load        = 1'b0;
    in_i.ready      = 1'b0;

    unique case (state_q)
      mm64a_pkg::StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          w_d    = in_i.message_word & byte_mask;
          nb_d   = nb_sat;
          last_d = in_i.is_last;
          if (in_i.is_first) begin
            // seed: length times m, xor seed when the product is back
            mul_req.start   = 1'b1;
            mul_req.operand = len_ext;
            state_d         = mm64a_pkg::StSeed;
          end else begin
            state_d = mm64a_pkg::StDispatch;
          end
        end
      end
      mm64a_pkg::StSeed: begin
        if (mul_rsp.done) begin
          h_d     = mm64a_pkg::MurSeed ^ mul_rsp.product;
          state_d = mm64a_pkg::StDispatch;
        end
      end
      mm64a_pkg::StDispatch: begin
        if (nb_q == mm64a_pkg::FullBytes) begin
          mul_req.start   = 1'b1;
          mul_req.operand = w_q;
          state_d         = mm64a_pkg::StKMul1;
        end else if (nb_q != 4'd0) begin
          // tail bytes: xor in, then one multiply of the hash
          h_d             = h_q ^ w_q;
          mul_req.start   = 1'b1;
          mul_req.operand = h_q ^ w_q;
          state_d         = mm64a_pkg::StHMul;
        end else begin
          state_d = mm64a_pkg::StPost;
        end
      end
      mm64a_pkg::StKMul1: begin
        if (mul_rsp.done) begin
          k_d             = prod_mix;
          mul_req.start   = 1'b1;
          mul_req.operand = prod_mix;
          state_d         = mm64a_pkg::StKMul2;
        end
      end
      mm64a_pkg::StKMul2: begin
        if (mul_rsp.done) begin
          h_d             = h_q ^ mul_rsp.product;
          mul_req.start   = 1'b1;
          mul_req.operand = h_q ^ mul_rsp.product;
          state_d         = mm64a_pkg::StHMul;
        end
      end
      mm64a_pkg::StHMul: begin
        if (mul_rsp.done) begin
          h_d     = mul_rsp.product;
          state_d = mm64a_pkg::StPost;
        end
      end
      mm64a_pkg::StPost: begin
        if (last_q) begin
          // finalization keeps h_q untouched
          mul_req.start   = 1'b1;
          mul_req.operand = h_q ^ (h_q >> mm64a_pkg::MurR);
          state_d         = mm64a_pkg::StFinal;
        end else begin
          state_d = mm64a_pkg::StIdle;
        end
      end
      mm64a_pkg::StFinal: begin
        if (mul_rsp.done) begin
          k_d     = prod_mix;
          state_d = mm64a_pkg::StEmit;
        end
      end
      mm64a_pkg::StEmit: begin
        // wait until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = mm64a_pkg::StIdle;
        end
      end
      default: begin
        state_d = mm64a_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mm64a_pkg::StIdle;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    w_q    <= w_d;
    nb_q   <= nb_d;
    last_q <= last_d;
    if (out_load) begin
      out_hash_q <= k_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.hash_value = out_hash_q;

  // the multiplier is never restarted while it works
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // no new transaction while a multiply is in flight
  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!mul_rsp.busy && !mul_rsp.done))
    else $error("input ready while multiplier active");

  // a product only comes back to a state that waits for it
  a_done_waited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == mm64a_pkg::StSeed || state_q == mm64a_pkg::StKMul1 ||
                      state_q == mm64a_pkg::StKMul2 || state_q == mm64a_pkg::StHMul ||
                      state_q == mm64a_pkg::StFinal))
    else $error("multiplier result not consumed");

  // a result appears only after the emit step
  a_out_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == mm64a_pkg::StEmit))
    else $error("result without finalization");

endmodule

`default_nettype wire

// ===== hdl/mm64a_mul.sv =====
// iterative 64-bit multiply by the hash constant on one 32x32 multiplier
`default_nettype none

module mm64a_mul (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mm64a_pkg::mul_req_t req_i,
  output mm64a_pkg::mul_rsp_t      rsp_o
);

  localparam logic [1:0] StepLoLo = 2'd0;
  localparam logic [1:0] StepHiLo = 2'd1;
  localparam logic [1:0] StepLoHi = 2'd2;

  localparam logic [31:0] MLo = mm64a_pkg::MurM[31:0];
  localparam logic [31:0] MHi = mm64a_pkg::MurM[63:32];

  logic        busy_q;
  logic        done_q;
  logic [1:0]  step_q;
  logic [63:0] a_q;
  logic [63:0] acc_q, acc_d;
  logic [31:0] x, y;
  logic [63:0] p;

  // partial product selection, cross terms only need their low half
  always_comb begin
    x = a_q[31:0];
    y = MLo;
    unique case (step_q)
      StepLoLo: begin
        x = a_q[31:0];
        y = MLo;
      end
      StepHiLo: begin
        x = a_q[63:32];
        y = MLo;
      end
      StepLoHi: begin
        x = a_q[31:0];
        y = MHi;
      end
      default: begin
        x = a_q[31:0];
        y = MLo;
      end
    endcase
    p = 64'(x) * 64'(y);
    if (step_q == StepLoLo) begin
      acc_d = p;
    end else begin
      acc_d = acc_q + {p[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= StepLoLo;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= StepLoLo;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == StepLoHi) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.operand;
    end
    if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

`default_nettype wire

// ===== test/murmur64a_hash_engine_tb.sv =====
// self-checking testbench for the murmur64a hash engine: directed and random message traffic
`timescale 1ns / 100ps

module murmur64a_hash_engine_tb;

  // hash constants, kept apart from the design package
  localparam logic [63:0] HASH_MUL  = 64'hc6a4a7935bd1e995;
  localparam int unsigned HASH_SHR  = 47;
  localparam logic [63:0] HASH_SEED = 64'h00000000000ce110;

  // full word byte count, the rest of a word is a tail
  localparam int unsigned WORD_BYTES = 8;

  // quiet cycles after the last pending hash; covers a trailing full word with seeding
  localparam int unsigned SETTLE_CYCLES = 40;

  // random stimulus size and run limit
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  // hash prediction and result checking
  class hash_scoreboard;
    logic [63:0] chain_hash;
    logic [63:0] pending_hashes[$];
    int unsigned words_seen;
    int unsigned hashes_checked;
    int unsigned mismatches;

    function new();
      chain_hash     = '0;
      words_seen     = 0;
      hashes_checked = 0;
      mismatches     = 0;
    endfunction

    static function logic [63:0] mix_word(input logic [63:0] h, input logic [63:0] k);
      logic [63:0] kk;
      kk = k * HASH_MUL;
      kk = kk ^ (kk >> HASH_SHR);
      kk = kk * HASH_MUL;
      return (h ^ kk) * HASH_MUL;
    endfunction

    static function logic [63:0] finish_hash(input logic [63:0] h);
      logic [63:0] f;
      f = h ^ (h >> HASH_SHR);
      f = f * HASH_MUL;
      return f ^ (f >> HASH_SHR);
    endfunction

    // accepted input transaction: advance the chain, queue a hash on a last word
    function void note_word(input logic [63:0] word, input logic [3:0] nbytes,
                            input logic [31:0] msg_len, input logic first, input logic last);
      logic [63:0] h;
      logic [63:0] len_ext;
      logic [63:0] keep;
      int unsigned count;
      h       = chain_hash;
      len_ext = {32'd0, msg_len};
      count   = (nbytes > WORD_BYTES) ? WORD_BYTES : nbytes;
      words_seen++;
      if (first) h = HASH_SEED ^ (len_ext * HASH_MUL);
      if (count == WORD_BYTES) begin
        h = mix_word(h, word);
      end else if (count != 0) begin
        keep = (64'd1 << (count * 8)) - 64'd1;
        h    = (h ^ (word & keep)) * HASH_MUL;
      end
      chain_hash = h;
      if (last) pending_hashes.push_back(finish_hash(h));
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // accepted output transaction against the oldest pending hash
    task check_hash(input logic [63:0] got);
      logic [63:0] want;
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("hash_value %h with no hash pending", got));
      end else begin
        want = pending_hashes.pop_front();
        hashes_checked++;
        if (got !== want)
          report_mismatch($sformatf("hash_value %h, expected %h", got, want));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  mm64a_in_if  in_bus ();
  mm64a_out_if out_bus ();

  murmur64a_hash_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  hash_scoreboard sb;

  // flow control knobs shared by the stimulus and the receiver
  bit          tx_steady;
  bit          rx_steady;
  int unsigned rx_hold_cycles;
  int unsigned items_sent;
  int unsigned messages_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // both channels are sampled at the rising edge, inputs only change at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready)
        sb.note_word(in_bus.message_word, in_bus.word_bytes, in_bus.message_length,
                     in_bus.is_first, in_bus.is_last);
      if (out_bus.valid && out_bus.ready)
        sb.check_hash(out_bus.hash_value);
    end
  end

  // receiver: random back-pressure, plus a long hold-off when the stimulus asks for one
  initial begin : receiver
    int unsigned rx_gap;
    rx_gap = 0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_gap > 0) begin
        out_bus.ready <= 1'b0;
        rx_gap--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!rx_steady && $urandom_range(3) == 0) rx_gap = pick_gap();
      end
    end
  end

  // one input transaction; entered and left at a falling edge
  task automatic send_item(input logic [63:0] word, input logic [3:0] nbytes,
                           input logic [31:0] msg_len, input logic first, input logic last);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.message_word   <= word;
    in_bus.word_bytes     <= nbytes;
    in_bus.message_length <= msg_len;
    in_bus.is_first       <= first;
    in_bus.is_last        <= last;
    in_bus.valid          <= 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // well-formed message of n_bytes random bytes; later words carry junk in the length field
  task automatic send_message(input int unsigned n_bytes, input logic [31:0] len_field);
    int unsigned full_words;
    int unsigned tail_bytes;
    full_words = n_bytes / WORD_BYTES;
    tail_bytes = n_bytes % WORD_BYTES;
    messages_sent++;
    if (n_bytes == 0) begin
      // empty message, the word content must not matter
      send_item(rand_word(), 4'd0, len_field, 1'b1, 1'b1);
    end else begin
      for (int unsigned i = 0; i < full_words; i++)
        send_item(rand_word(), 4'd8, (i == 0) ? len_field : $urandom, i == 0,
                  (i == full_words - 1) && (tail_bytes == 0));
      if (tail_bytes != 0)
        send_item(rand_word(), 4'(tail_bytes), (full_words == 0) ? len_field : $urandom,
                  full_words == 0, 1'b1);
    end
  endtask

  // sender pause: nothing offered until every pending hash is back and the engine is quiet
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.pending_hashes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_random_message();
    int unsigned r;
    int unsigned n_bytes;
    r = $urandom_range(99);
    if (r < 50)      n_bytes = $urandom_range(16);
    else if (r < 85) n_bytes = $urandom_range(48, 17);
    else             n_bytes = $urandom_range(120, 49);
    // a dishonest length only changes the seed
    send_message(n_bytes, ($urandom_range(9) == 0) ? $urandom : 32'(n_bytes));
  endtask

  // out-of-protocol transaction: any flags, any byte count, any length
  task automatic send_noise_item();
    send_item(rand_word(), 4'($urandom_range(15)), $urandom,
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  initial begin : stimulus
    int unsigned target;
    sb             = new();
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    rx_hold_cycles = 0;
    items_sent     = 0;
    messages_sent  = 0;

    // every input known from time zero
    in_bus.valid          = 1'b0;
    in_bus.message_word   = '0;
    in_bus.word_bytes     = '0;
    in_bus.message_length = '0;
    in_bus.is_first       = 1'b0;
    in_bus.is_last        = 1'b0;

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty message, extremes of word and length
    send_item(rand_word(), 4'd0, 32'd0, 1'b1, 1'b1);
    send_item({64{1'b1}}, 4'd8, 32'd8, 1'b1, 1'b1);
    send_item(64'd0, 4'd8, 32'd0, 1'b1, 1'b1);
    send_item({64{1'b1}}, 4'd8, 32'hffff_ffff, 1'b1, 1'b1);
    // single tails of one and seven bytes, upper bytes filled with junk to check masking
    send_item({64{1'b1}}, 4'd1, 32'd1, 1'b1, 1'b1);
    send_item(rand_word(), 4'd7, 32'd7, 1'b1, 1'b1);
    // byte counts above eight behave as a full word
    send_item(rand_word(), 4'd15, 32'd8, 1'b1, 1'b1);
    send_item(rand_word(), 4'd9, 32'd8, 1'b1, 1'b1);
    // tail on a word that is not last, message continues with a full word
    send_item(rand_word(), 4'd3, 32'd11, 1'b1, 1'b0);
    send_item(rand_word(), 4'd8, 32'd0, 1'b0, 1'b1);
    // continuation without a first word picks up the running hash
    send_item(rand_word(), 4'd8, $urandom, 1'b0, 1'b1);
    // empty word in the middle of a message
    send_item(rand_word(), 4'd8, 32'd13, 1'b1, 1'b0);
    send_item(rand_word(), 4'd0, $urandom, 1'b0, 1'b0);
    send_item(rand_word(), 4'd5, $urandom, 1'b0, 1'b1);
    // multi-word messages
    send_message(19, 32'd19);
    send_message(16, 32'd16);
    wait_drained();

    // long receiver hold-off while the sender keeps offering back to back
    tx_steady      = 1'b1;
    rx_hold_cycles = 300;
    for (int i = 0; i < 8; i++) send_random_message();
    tx_steady = 1'b0;
    wait_drained();

    // random phases: plain, sender back to back, receiver always ready, another hold-off
    target = items_sent + RANDOM_ITEMS;
    for (int phase = 0; phase < 4; phase++) begin
      tx_steady = (phase == 1);
      rx_steady = (phase == 2);
      if (phase == 3) rx_hold_cycles = 150;
      while (items_sent < target - RANDOM_ITEMS + RANDOM_ITEMS * (phase + 1) / 4) begin
        if ($urandom_range(99) < 85) send_random_message();
        else send_noise_item();
      end
      wait_drained();
    end

    $display("covered %0d input transactions in %0d messages plus noise, %0d hashes checked",
             sb.words_seen, messages_sent, sb.hashes_checked);
    $display("included empty, tail, oversized and unframed words, hold-offs and idle gaps");
    if (sb.mismatches == 0 && sb.pending_hashes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop for a hung handshake
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("timeout with %0d hashes still pending", sb.pending_hashes.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mm64a_pkg.sv
hdl/mm64a_if.sv
hdl/mm64a_mul.sv
hdl/murmur64a_hash_engine.sv
test/murmur64a_hash_engine_tb.sv
